/* rtl/ipd_pkg.sv */
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants for the IQ packet deframer
// Word formats on both channels and on the internal queue, packet kinds and
// header type codes.
// ----------------------------------------------------------------------------
package ipd_pkg;

    // header type codes
    localparam logic [7:0] TYPE_NARROW_0   = 8'h04;
    localparam logic [7:0] TYPE_NARROW_1A  = 8'h84;
    localparam logic [7:0] TYPE_NARROW_1B  = 8'h82;
    localparam logic [7:0] TYPE_WIDE_A_0   = 8'hA4;
    localparam logic [7:0] TYPE_WIDE_A_1   = 8'h85;
    localparam logic [7:0] TYPE_WIDE_B_0   = 8'h84;
    localparam logic [7:0] TYPE_WIDE_B_1   = 8'h81;

    localparam logic [15:0] SEQ_WRAP       = 16'hFFFF;

    // bytes per I/Q pair
    localparam logic [2:0] PAIR_BYTES_NARROW = 3'd4;
    localparam logic [2:0] PAIR_BYTES_WIDE   = 3'd6;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_DROP   = 2'd0,
        KIND_NARROW = 2'd1,
        KIND_WIDE   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic signed [23:0] sample_i;
        logic signed [23:0] sample_q;
        logic               wide_format;
        logic [15:0]        packet_gap;
        logic               sample_last;
    } t_out_word;

    // payload byte handed from the header parser to the pair assembler
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        wide;
        logic        pair_start;
        logic        final_byte;
        logic [15:0] gap;
    } t_queue_word;

endpackage

/* rtl/ipd_front.sv */
// ----------------------------------------------------------------------------
// ipd_front: packet header parser
// Tracks byte position, classifies the packet type, checks the sequence
// number and forwards payload bytes of known types to the queue.
// ----------------------------------------------------------------------------
module ipd_front #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ipd_pkg::t_in_word    i_word,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output ipd_pkg::t_queue_word o_push_word
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [POS_W-1:0] POS_TYPE0   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TYPE1   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SEQ_LO  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SEQ_HI  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LIMIT   = POS_W'(MAX_PACKET_BYTES);

    function automatic ipd_pkg::t_kind classify(input logic [7:0] t0, input logic [7:0] t1);
        ipd_pkg::t_kind k;
        k = ipd_pkg::KIND_DROP;
        if (t0 == ipd_pkg::TYPE_NARROW_0 &&
            (t1 == ipd_pkg::TYPE_NARROW_1A || t1 == ipd_pkg::TYPE_NARROW_1B)) begin
            k = ipd_pkg::KIND_NARROW;
        end else if ((t0 == ipd_pkg::TYPE_WIDE_A_0 && t1 == ipd_pkg::TYPE_WIDE_A_1) ||
                     (t0 == ipd_pkg::TYPE_WIDE_B_0 && t1 == ipd_pkg::TYPE_WIDE_B_1)) begin
            k = ipd_pkg::KIND_WIDE;
        end
        return k;
    endfunction

    logic [POS_W-1:0] r_pos,    n_pos;
    ipd_pkg::t_kind   r_kind,   n_kind;
    logic [7:0]       r_type,   n_type;
    logic [7:0]       r_seq_lo, n_seq_lo;
    logic [15:0]      r_prev,   n_prev;
    logic [15:0]      r_gap,    n_gap;

    logic             accept;
    logic [POS_W-1:0] pos_cur;
    ipd_pkg::t_kind   kind_cur;
    logic             in_range;
    logic             kind_known;
    logic [15:0]      seq;
    logic [15:0]      diff;

    assign o_ready  = i_push_ready;
    assign accept   = i_valid && o_ready;

    // a first-byte mark restarts the packet regardless of position
    assign pos_cur  = i_word.first_byte ? POS_TYPE0 : r_pos;
    assign kind_cur = i_word.first_byte ? ipd_pkg::KIND_DROP : r_kind;
    assign in_range = pos_cur < POS_LIMIT;

    always_comb begin
        case (kind_cur) inside
            ipd_pkg::KIND_NARROW,
            ipd_pkg::KIND_WIDE:   kind_known = 1'b1;
            default:              kind_known = 1'b0;
        endcase
    end

    assign seq  = {i_word.data_byte, r_seq_lo};
    assign diff = seq - r_prev;

    always_comb begin
        n_pos    = r_pos;
        n_kind   = r_kind;
        n_type   = r_type;
        n_seq_lo = r_seq_lo;
        n_prev   = r_prev;
        n_gap    = r_gap;
        if (accept) begin
            n_pos  = pos_cur;
            n_kind = kind_cur;
            if (in_range) begin
                if (pos_cur == POS_TYPE0) begin
                    n_type = i_word.data_byte;
                    n_kind = ipd_pkg::KIND_DROP;
                end else if (pos_cur == POS_TYPE1) begin
                    n_kind = classify(r_type, i_word.data_byte);
                end else if (pos_cur == POS_SEQ_LO) begin
                    n_seq_lo = i_word.data_byte;
                end else if (pos_cur == POS_SEQ_HI) begin
                    n_gap  = (diff > 16'd1) ? diff : 16'd0;
                    n_prev = (seq == ipd_pkg::SEQ_WRAP) ? 16'd0 : seq;
                end
                n_pos = pos_cur + POS_W'(1);
            end
            if (i_word.final_byte) begin
                n_pos  = POS_TYPE0;
                n_kind = ipd_pkg::KIND_DROP;
            end
        end
    end

    assign o_push_valid = accept && in_range && (pos_cur > POS_SEQ_HI) && kind_known;

    always_comb begin
        o_push_word.data_byte  = i_word.data_byte;
        o_push_word.wide       = (kind_cur == ipd_pkg::KIND_WIDE);
        o_push_word.pair_start = (pos_cur == POS_PAYLOAD);
        o_push_word.final_byte = i_word.final_byte;
        o_push_word.gap        = r_gap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_kind   <= ipd_pkg::KIND_DROP;
            r_type   <= '0;
            r_seq_lo <= '0;
            r_prev   <= '0;
            r_gap    <= '0;
        end else begin
            r_pos    <= n_pos;
            r_kind   <= n_kind;
            r_type   <= n_type;
            r_seq_lo <= n_seq_lo;
            r_prev   <= n_prev;
            r_gap    <= n_gap;
        end
    end

endmodule

/* rtl/ipd_queue.sv */
// ----------------------------------------------------------------------------
// ipd_queue: short payload byte queue
// Small register FIFO between the header parser and the pair assembler.
// ----------------------------------------------------------------------------
module ipd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    output logic                 o_push_ready,
    input  ipd_pkg::t_queue_word i_push_word,
    output logic                 o_pop_valid,
    input  logic                 i_pop_ready,
    output ipd_pkg::t_queue_word o_pop_word
);

    localparam int PTR_W = $clog2(ipd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ipd_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ipd_pkg::QUEUE_DEPTH);

    ipd_pkg::t_queue_word r_mem [ipd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != FULL_COUNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_word   = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(ipd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(ipd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/ipd_back.sv */
// ----------------------------------------------------------------------------
// ipd_back: I/Q pair assembler
// Collects payload bytes into 16-bit or 24-bit pairs, scales to Q1.23 and
// holds each finished pair in the output register.
// ----------------------------------------------------------------------------
module ipd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pop_valid,
    output logic                 o_pop_ready,
    input  ipd_pkg::t_queue_word i_pop_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ipd_pkg::t_out_word   o_word
);

    logic [4:0][7:0]    r_elem;
    logic [2:0]         r_idx, n_idx;
    logic               r_out_valid;
    ipd_pkg::t_out_word r_out_word;

    logic               slot_free;
    logic [2:0]         idx;
    logic [2:0]         need;
    logic               complete;
    logic               pop;
    logic               load;
    ipd_pkg::t_out_word pair;

    assign slot_free = !r_out_valid || i_ready;
    assign need      = i_pop_word.wide ? ipd_pkg::PAIR_BYTES_WIDE : ipd_pkg::PAIR_BYTES_NARROW;

    always_comb begin
        idx = i_pop_word.pair_start ? 3'd0 : r_idx;
        if (idx >= need) begin
            idx = 3'd0;
        end
    end

    assign complete    = (idx + 3'd1) == need;
    assign o_pop_ready = !complete || slot_free;
    assign pop         = i_pop_valid && o_pop_ready;
    assign load        = pop && complete;

    // the closing byte is taken live, never stored
    always_comb begin
        if (i_pop_word.wide) begin
            pair.sample_i = {r_elem[2], r_elem[1], r_elem[0]};
            pair.sample_q = {i_pop_word.data_byte, r_elem[4], r_elem[3]};
        end else begin
            pair.sample_i = {r_elem[1], r_elem[0], 8'h00};
            pair.sample_q = {i_pop_word.data_byte, r_elem[2], 8'h00};
        end
        pair.wide_format = i_pop_word.wide;
        pair.packet_gap  = i_pop_word.gap;
        pair.sample_last = i_pop_word.final_byte;
    end

    always_comb begin
        n_idx = r_idx;
        if (pop) begin
            n_idx = complete ? 3'd0 : idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && !complete) begin
            r_elem[idx] <= i_pop_word.data_byte;
        end
        if (load) begin
            r_out_word <= pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

/* rtl/iq_packet_deframer_top.sv */
// ----------------------------------------------------------------------------
// iq_packet_deframer_top: IQ sample packet deframer
// Parses packet headers, reports sequence gaps and emits Q1.23 I/Q pairs
// from 16-bit or 24-bit payloads.
//
//   channel  direction  handshake               word
//   in       input      i_in_valid/o_in_ready   ipd_pkg::t_in_word (one byte)
//   out      output     o_out_valid/i_out_ready ipd_pkg::t_out_word (one pair)
//
// One byte per cycle sustained while the queue has room; a pair appears once
// its closing byte has passed the queue entry and the output register.
// The two-entry queue sets the stall behavior: input stalls only when it is
// full, which happens once the output register is held by a stalled sink.
// Synchronous active-low reset clears position, kind, sequence, queue and
// output valid; no clearing pass.
// ----------------------------------------------------------------------------
module iq_packet_deframer_top #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ipd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ipd_pkg::t_out_word o_out_word
);

    logic                 w_push_valid;
    logic                 w_push_ready;
    ipd_pkg::t_queue_word w_push_word;
    logic                 w_pop_valid;
    logic                 w_pop_ready;
    ipd_pkg::t_queue_word w_pop_word;

    ipd_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_word       (i_in_word),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_word  (w_push_word)
    );

    ipd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_word  (w_push_word),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_word   (w_pop_word)
    );

    ipd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (w_pop_valid),
        .o_pop_ready  (w_pop_ready),
        .i_pop_word   (w_pop_word),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_word       (o_out_word)
    );

`ifndef ASSERT_OFF
    // input stalls only because the queue holds words
    a_stall_means_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_pop_valid)
        else $error("input stalled with empty queue");

    // narrow samples are 16-bit values shifted up by 8
    a_narrow_low_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.wide_format) |->
            (o_out_word.sample_i[7:0] == 8'h00 && o_out_word.sample_q[7:0] == 8'h00))
        else $error("narrow sample has nonzero low byte");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
